// File: hw/rtl/qked_pkg.sv
// ----------------------------------------------------------------------------
// qked_pkg
// Shared types, codes and the quadrature transition lookup for the knob
// event decoder.
// ----------------------------------------------------------------------------
package qked_pkg;

  // fixed width of the debounce window register
  localparam int DEBOUNCE_W = 20;

  // reset values of the configuration registers
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 20'd5000;
  localparam logic                  ACTIVE_LOW_RESET = 1'b1;

  // idle pulled-up a/b levels, a in bit 1
  localparam logic [1:0] AB_IDLE = 2'b11;

  // configuration register indexes
  localparam logic CFG_DEBOUNCE_TICKS    = 1'b0;
  localparam logic CFG_BUTTON_ACTIVE_LOW = 1'b1;

  // command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_RESYNC = 1'b1;

  typedef enum logic [1:0] {
    KIND_LEFT   = 2'd0,
    KIND_RIGHT  = 2'd1,
    KIND_BUTTON = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MOVE_NONE,
    MOVE_LEFT,
    MOVE_RIGHT
  } move_t;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_ticks;
    logic                  button_active_low;
  } cfg_t;

  typedef struct packed {
    kind_t kind;
    logic  last_of_run;
  } result_t;

  // results caused by one accepted request, first is always used first
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // quadrature transition table, index is {previous_ab, current_ab}
  function automatic move_t quad_move(input logic [3:0] idx);
    move_t mv;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  mv = MOVE_LEFT;
      4'd2, 4'd4, 4'd11, 4'd13: mv = MOVE_RIGHT;
      default:                  mv = MOVE_NONE;
    endcase
    return mv;
  endfunction

endpackage

// File: hw/rtl/qked_decode.sv
// ----------------------------------------------------------------------------
// qked_decode
// Knob state and single-pass decode: quadrature step, button edge and the
// two saturating lockout counters.
// ----------------------------------------------------------------------------
module qked_decode #(
  parameter int TIMER_WIDTH = 20
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            command,
  input  logic            pin_a_level,
  input  logic            pin_b_level,
  input  logic            button_level,
  input  qked_pkg::cfg_t  cfg,
  output qked_pkg::push_t push
);

  localparam int CMP_W = (TIMER_WIDTH > qked_pkg::DEBOUNCE_W) ?
                         TIMER_WIDTH : qked_pkg::DEBOUNCE_W;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  logic [1:0]             previous_ab;
  logic [TIMER_WIDTH-1:0] ticks_since_step;
  logic [TIMER_WIDTH-1:0] ticks_since_button;
  logic                   button_was_active;

  logic [1:0]             cur_ab;
  logic [TIMER_WIDTH-1:0] step_elapsed;
  logic [TIMER_WIDTH-1:0] button_elapsed;
  logic                   step_ok;
  logic                   button_ok;
  qked_pkg::move_t        mv;
  logic                   active;
  logic                   step_fire;
  logic                   button_fire;
  logic                   sample;

  // elapsed counters advance once per request, saturating
  assign step_elapsed   = (ticks_since_step == TIMER_MAX) ?
                          TIMER_MAX : ticks_since_step + 1'b1;
  assign button_elapsed = (ticks_since_button == TIMER_MAX) ?
                          TIMER_MAX : ticks_since_button + 1'b1;
  assign step_ok   = CMP_W'(step_elapsed) >= CMP_W'(cfg.debounce_ticks);
  assign button_ok = CMP_W'(button_elapsed) >= CMP_W'(cfg.debounce_ticks);

  // step and button decision
  assign cur_ab      = {pin_a_level, pin_b_level};
  assign sample      = (command == qked_pkg::CMD_SAMPLE);
  assign mv          = qked_pkg::quad_move({previous_ab, cur_ab});
  assign active      = cfg.button_active_low ? ~button_level : button_level;
  assign step_fire   = accept && sample && (mv != qked_pkg::MOVE_NONE) && step_ok;
  assign button_fire = accept && sample && active && !button_was_active && button_ok;

  // pack results, step first then button
  always_comb begin
    push.count              = 2'd0;
    push.first.kind         = qked_pkg::KIND_BUTTON;
    push.first.last_of_run  = 1'b1;
    push.second.kind        = qked_pkg::KIND_BUTTON;
    push.second.last_of_run = 1'b1;
    if (step_fire) begin
      push.first.kind        = (mv == qked_pkg::MOVE_RIGHT) ?
                               qked_pkg::KIND_RIGHT : qked_pkg::KIND_LEFT;
      push.first.last_of_run = !button_fire;
      push.count             = button_fire ? 2'd2 : 2'd1;
    end else if (button_fire) begin
      push.count = 2'd1;
    end
  end

  // knob state
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_ab        <= qked_pkg::AB_IDLE;
      ticks_since_step   <= '0;
      ticks_since_button <= TIMER_MAX;
      button_was_active  <= 1'b0;
    end else if (accept) begin
      previous_ab        <= cur_ab;
      ticks_since_step   <= step_fire ? '0 : step_elapsed;
      ticks_since_button <= button_fire ? '0 : button_elapsed;
      if (sample) begin
        button_was_active <= active;
      end
    end
  end

endmodule

// File: hw/rtl/qked_out_buf.sv
// ----------------------------------------------------------------------------
// qked_out_buf
// Three-entry result buffer: takes up to two results a cycle, hands out one
// a cycle unless stalled, and holds off requests when two free entries are not sure.
// ----------------------------------------------------------------------------
module qked_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  qked_pkg::push_t   push,
  input  logic              out_stall,
  output logic              room,
  output logic              out_valid,
  output qked_pkg::result_t head
);

  localparam int DEPTH = 3;

  qked_pkg::result_t slots [DEPTH];
  qked_pkg::result_t slots_next [DEPTH];
  logic [1:0]        count;
  logic [1:0]        count_next;
  logic [1:0]        kept;
  logic              pop;

  assign out_valid = (count != 2'd0);
  assign head      = slots[0];
  assign pop       = out_valid && !out_stall;
  // two free entries after this cycle's pop
  assign room      = !((count == 2'd3) || ((count == 2'd2) && !pop));

  // shift out the head, then append new results behind what is kept
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      slots_next[i] = slots[i];
    end
    kept = count;
    if (pop) begin
      slots_next[0] = slots[1];
      slots_next[1] = slots[2];
      kept          = count - 2'd1;
    end
    if (push.count != 2'd0) begin
      slots_next[kept] = push.first;
    end
    if (push.count == 2'd2) begin
      slots_next[2'(kept + 2'd1)] = push.second;
    end
    count_next = kept + push.count;
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      slots[i] <= slots_next[i];
    end
  end

endmodule

// File: hw/rtl/quadrature_knob_event_decoder.sv
// A result is written into the output buffer and offered from its head.
// Throughput: one request per cycle unless in_stall, one result per cycle unless
// out_stall; two results of one request leave in turn by the single result port.
// Reset: synchronous; config returns to 5000 ticks and active-low button,
// steps are locked out for one window, the button is allowed at once.
// ----------------------------------------------------------------------------
// quadrature_knob_event_decoder
// Quadrature knob and push button event decoder with debounce lockout.
// ----------------------------------------------------------------------------
module quadrature_knob_event_decoder #(
  parameter int TIMER_WIDTH = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [qked_pkg::DEBOUNCE_W-1:0] cfg_data,
  // sample channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            command,
  input  logic                            pin_a_level,
  input  logic                            pin_b_level,
  input  logic                            button_level,
  // event channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      event_kind,
  output logic                            last_of_run
);

  qked_pkg::cfg_t    cfg;
  qked_pkg::push_t   push;
  qked_pkg::result_t head;
  logic              room;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = !room;
  assign accept    = in_valid && room;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks    <= qked_pkg::DEBOUNCE_RESET;
      cfg.button_active_low <= qked_pkg::ACTIVE_LOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qked_pkg::CFG_DEBOUNCE_TICKS:    cfg.debounce_ticks    <= cfg_data;
        qked_pkg::CFG_BUTTON_ACTIVE_LOW: cfg.button_active_low <= cfg_data[0];
      endcase
    end
  end

  qked_decode #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_decode (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .command      (command),
    .pin_a_level  (pin_a_level),
    .pin_b_level  (pin_b_level),
    .button_level (button_level),
    .cfg          (cfg),
    .push         (push)
  );

  qked_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_stall (out_stall),
    .room      (room),
    .out_valid (out_valid),
    .head      (head)
  );

  assign event_kind  = head.kind;
  assign last_of_run = head.last_of_run;

endmodule
